FILE: hdl/alpha_over_blend_assert.svh
// Assertion macros used by the alpha_over_blend checker.
`ifndef ALPHA_OVER_BLEND_ASSERT_SVH
`define ALPHA_OVER_BLEND_ASSERT_SVH

// Same-cycle implication, clocked on clk, switched off while rst is high.
`define AOB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clk, switched off while rst is high.
`define AOB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/aob_pkg.sv
// Types, constants and the divide-by-255 helper for the alpha_over_blend block.
package aob_pkg;

   localparam int ChanN     = 3;   // colour channels per pixel
   localparam int PixW      = 8;
   localparam int ProdW     = 16;  // 8 x 8 product
   localparam int WideW     = 24;  // 8 x 16 product
   localparam int NumW      = 17;  // blend numerator
   localparam int QuoW      = 9;   // quotient before wrap to 8 bits
   localparam int QStepN    = 3;   // quotient bits per divider stage
   localparam int PipeDepth = 7;

   localparam logic [PixW-1:0] FullScale = 8'd255;
   localparam logic [WideW-1:0] RoundHalf = 24'd127;

   // ceil(2^32 / 255): exact floor(y / 255) for any y below 2^24
   localparam logic [24:0] Div255Recip = 25'd16843010;
   localparam int          Div255Shift = 32;

   typedef logic [PixW-1:0]  pix_type;
   typedef logic [ProdW-1:0] prod_type;
   typedef logic [WideW-1:0] wide_type;
   typedef logic [NumW-1:0]  num_type;
   typedef logic [QuoW-1:0]  quo_type;
   typedef logic [QStepN-1:0] qstep_type;

   typedef pix_type   [ChanN-1:0] chan_pix_type;
   typedef prod_type  [ChanN-1:0] chan_prod_type;
   typedef wide_type  [ChanN-1:0] chan_wide_type;
   typedef num_type   [ChanN-1:0] chan_num_type;
   typedef quo_type   [ChanN-1:0] chan_quo_type;
   typedef qstep_type [ChanN-1:0] chan_qstep_type;

   // round(x / 255) as (x + 127) / 255, via reciprocal multiply
   function automatic prod_type div255_round(input wide_type x);
      wide_type    y;
      logic [48:0] p;
      y = x + RoundHalf;
      p = 49'(y) * 49'(Div255Recip);
      return p[Div255Shift +: ProdW];
   endfunction

endpackage

FILE: hdl/aob_if.sv
// Pixel request and blend response channel interfaces.
interface aob_req_if;
   logic              valid;
   logic              ready;
   aob_pkg::pix_type  src_c0;
   aob_pkg::pix_type  src_c1;
   aob_pkg::pix_type  src_c2;
   aob_pkg::pix_type  src_alpha;
   aob_pkg::pix_type  dst_c0;
   aob_pkg::pix_type  dst_c1;
   aob_pkg::pix_type  dst_c2;
   aob_pkg::pix_type  dst_alpha;

   modport source (output valid, output src_c0, output src_c1, output src_c2,
                   output src_alpha, output dst_c0, output dst_c1, output dst_c2,
                   output dst_alpha, input ready);
   modport sink   (input valid, input src_c0, input src_c1, input src_c2,
                   input src_alpha, input dst_c0, input dst_c1, input dst_c2,
                   input dst_alpha, output ready);
endinterface

interface aob_rsp_if;
   logic              valid;
   logic              ready;
   aob_pkg::pix_type  out_c0;
   aob_pkg::pix_type  out_c1;
   aob_pkg::pix_type  out_c2;
   aob_pkg::pix_type  out_alpha;

   modport source (output valid, output out_c0, output out_c1, output out_c2,
                   output out_alpha, input ready);
   modport sink   (input valid, input out_c0, input out_c1, input out_c2,
                   input out_alpha, output ready);
endinterface

FILE: hdl/aob_div_step.sv
// One divider stage: three restoring quotient bits for each colour channel.
module aob_div_step (
   input  aob_pkg::chan_num_type   rem_in,
   input  aob_pkg::num_type        div_lo,
   output aob_pkg::chan_num_type   rem_out,
   output aob_pkg::chan_qstep_type quo
);

   always_comb begin
      aob_pkg::num_type r;
      aob_pkg::num_type t;
      for (int ch = 0; ch < aob_pkg::ChanN; ch++) begin
         r = rem_in[ch];
         for (int j = aob_pkg::QStepN - 1; j >= 0; j--) begin
            t = div_lo << j;
            if (r >= t) begin
               r          = r - t;
               quo[ch][j] = 1'b1;
            end else begin
               quo[ch][j] = 1'b0;
            end
         end
         rem_out[ch] = r;
      end
   end

endmodule

FILE: hdl/alpha_over_blend.sv
// alpha_over_blend: straight-alpha 8-bit source-over pixel compositor.
//
// Channels: req_px (sink) carries one source and one destination pixel per
// transfer; rsp_px (source) carries the blended pixel. Both use valid/ready,
// a transfer happens on a rising clock edge with valid and ready high.
// Every request transfer gives exactly one response transfer, in order.
//
// Throughput: one pixel per clock while rsp_px.ready is high. The block has
// seven register stages (two multiply stages, the divide-by-255 rounding
// stage, the numerator sum, and three divider stages of three quotient bits
// each, the last feeding the output register).
//
// Stalls: each stage holds its item until the stage after it frees up, so
// bubbles collapse and req_px.ready only drops once every stage is full and
// rsp_px.ready is low. Nothing is lost or repeated while stalled.
// Reset (synchronous, active high) empties the pipeline; rsp_px.valid is low
// in the cycle after reset.
//
// Transparent source (or zero result alpha): destination passes unchanged.
module alpha_over_blend (
   input  logic      clock,
   input  logic      reset,
   aob_req_if.sink   req_px,
   aob_rsp_if.source rsp_px
);

   localparam int Depth = aob_pkg::PipeDepth;

   // stage occupancy and back-pressure chain
   logic [Depth:1]   vld_ff;
   logic [Depth+1:1] stg_rdy;

   always_comb begin
      stg_rdy[Depth+1] = rsp_px.ready;
      for (int i = Depth; i >= 1; i--) begin
         stg_rdy[i] = !vld_ff[i] || stg_rdy[i+1];
      end
   end

   assign req_px.ready = stg_rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stg_rdy[1]) begin
            vld_ff[1] <= req_px.valid;
         end
         for (int i = 2; i <= Depth; i++) begin
            if (stg_rdy[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 1: inverse source alpha, da*(255-sa) and s*sa
   // ---------------------------------------------------------------
   aob_pkg::chan_pix_type  req_s;
   aob_pkg::chan_pix_type  req_d;
   aob_pkg::pix_type       s1_inv;

   assign req_s  = {req_px.src_c2, req_px.src_c1, req_px.src_c0};
   assign req_d  = {req_px.dst_c2, req_px.dst_c1, req_px.dst_c0};
   assign s1_inv = aob_pkg::FullScale - req_px.src_alpha;

   aob_pkg::prod_type      s1_x_ff;
   aob_pkg::chan_prod_type s1_ss_ff;
   aob_pkg::chan_pix_type  s1_d_ff;
   aob_pkg::pix_type       s1_sa_ff;
   aob_pkg::pix_type       s1_da_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         s1_x_ff <= aob_pkg::prod_type'(req_px.dst_alpha) * aob_pkg::prod_type'(s1_inv);
         for (int ch = 0; ch < aob_pkg::ChanN; ch++) begin
            s1_ss_ff[ch] <= aob_pkg::prod_type'(req_s[ch])
                          * aob_pkg::prod_type'(req_px.src_alpha);
         end
         s1_d_ff  <= req_d;
         s1_sa_ff <= req_px.src_alpha;
         s1_da_ff <= req_px.dst_alpha;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: rounded alpha term, d*da*(255-sa)
   // ---------------------------------------------------------------
   aob_pkg::prod_type      s2_qa_full;
   assign s2_qa_full = aob_pkg::div255_round(aob_pkg::wide_type'(s1_x_ff));

   aob_pkg::pix_type       s2_qa_ff;
   aob_pkg::chan_wide_type s2_pd_ff;
   aob_pkg::chan_prod_type s2_ss_ff;
   aob_pkg::chan_pix_type  s2_d_ff;
   aob_pkg::pix_type       s2_sa_ff;
   aob_pkg::pix_type       s2_da_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[2]) begin
         s2_qa_ff <= s2_qa_full[aob_pkg::PixW-1:0];   // never above 255
         for (int ch = 0; ch < aob_pkg::ChanN; ch++) begin
            s2_pd_ff[ch] <= aob_pkg::wide_type'(s1_d_ff[ch])
                          * aob_pkg::wide_type'(s1_x_ff);
         end
         s2_ss_ff <= s1_ss_ff;
         s2_d_ff  <= s1_d_ff;
         s2_sa_ff <= s1_sa_ff;
         s2_da_ff <= s1_da_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: output alpha, rounded destination colour terms
   // ---------------------------------------------------------------
   aob_pkg::pix_type       s3_oa_ff;
   aob_pkg::chan_prod_type s3_qd_ff;
   aob_pkg::chan_prod_type s3_ss_ff;
   logic                   s3_pass_ff;
   aob_pkg::chan_pix_type  s3_d_ff;
   aob_pkg::pix_type       s3_da_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[3]) begin
         s3_oa_ff <= s2_sa_ff + s2_qa_ff;             // bounded by 255
         for (int ch = 0; ch < aob_pkg::ChanN; ch++) begin
            s3_qd_ff[ch] <= aob_pkg::div255_round(s2_pd_ff[ch]);
         end
         s3_ss_ff   <= s2_ss_ff;
         s3_pass_ff <= (s2_sa_ff == '0);
         s3_d_ff    <= s2_d_ff;
         s3_da_ff   <= s2_da_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: numerator with half-divisor rounding
   // ---------------------------------------------------------------
   aob_pkg::chan_num_type  s4_num_ff;
   aob_pkg::pix_type       s4_oa_ff;
   logic                   s4_pass_ff;
   aob_pkg::chan_pix_type  s4_d_ff;
   aob_pkg::pix_type       s4_da_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[4]) begin
         for (int ch = 0; ch < aob_pkg::ChanN; ch++) begin
            s4_num_ff[ch] <= aob_pkg::num_type'(s3_ss_ff[ch])
                           + aob_pkg::num_type'(s3_qd_ff[ch])
                           + aob_pkg::num_type'(s3_oa_ff >> 1);
         end
         s4_oa_ff   <= s3_oa_ff;
         s4_pass_ff <= s3_pass_ff || (s3_oa_ff == '0);
         s4_d_ff    <= s3_d_ff;
         s4_da_ff   <= s3_da_ff;
      end
   end

   // ---------------------------------------------------------------
   // stages 5..7: restoring divide by oa, quotient bits 8..6, 5..3, 2..0
   // quotient stays below 512, so the top step starts at oa << 8
   // ---------------------------------------------------------------
   aob_pkg::chan_num_type   d5_rem;
   aob_pkg::chan_qstep_type d5_quo;
   aob_pkg::chan_num_type   d6_rem;
   aob_pkg::chan_qstep_type d6_quo;
   aob_pkg::chan_num_type   d7_rem;
   aob_pkg::chan_qstep_type d7_quo;

   aob_pkg::chan_num_type  s5_rem_ff;
   aob_pkg::chan_quo_type  s5_quo_ff;
   aob_pkg::pix_type       s5_oa_ff;
   logic                   s5_pass_ff;
   aob_pkg::chan_pix_type  s5_d_ff;
   aob_pkg::pix_type       s5_da_ff;

   aob_pkg::chan_num_type  s6_rem_ff;
   aob_pkg::chan_quo_type  s6_quo_ff;
   aob_pkg::pix_type       s6_oa_ff;
   logic                   s6_pass_ff;
   aob_pkg::chan_pix_type  s6_d_ff;
   aob_pkg::pix_type       s6_da_ff;

   aob_div_step u_div5 (
      .rem_in  (s4_num_ff),
      .div_lo  (aob_pkg::num_type'(s4_oa_ff) << (2 * aob_pkg::QStepN)),
      .rem_out (d5_rem),
      .quo     (d5_quo)
   );

   aob_div_step u_div6 (
      .rem_in  (s5_rem_ff),
      .div_lo  (aob_pkg::num_type'(s5_oa_ff) << aob_pkg::QStepN),
      .rem_out (d6_rem),
      .quo     (d6_quo)
   );

   aob_div_step u_div7 (
      .rem_in  (s6_rem_ff),
      .div_lo  (aob_pkg::num_type'(s6_oa_ff)),
      .rem_out (d7_rem),
      .quo     (d7_quo)
   );

   always_ff @(posedge clock) begin
      if (stg_rdy[5]) begin
         s5_rem_ff <= d5_rem;
         for (int ch = 0; ch < aob_pkg::ChanN; ch++) begin
            s5_quo_ff[ch] <= aob_pkg::quo_type'(d5_quo[ch]) << (2 * aob_pkg::QStepN);
         end
         s5_oa_ff   <= s4_oa_ff;
         s5_pass_ff <= s4_pass_ff;
         s5_d_ff    <= s4_d_ff;
         s5_da_ff   <= s4_da_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[6]) begin
         s6_rem_ff <= d6_rem;
         for (int ch = 0; ch < aob_pkg::ChanN; ch++) begin
            s6_quo_ff[ch] <= s5_quo_ff[ch]
                           | (aob_pkg::quo_type'(d6_quo[ch]) << aob_pkg::QStepN);
         end
         s6_oa_ff   <= s5_oa_ff;
         s6_pass_ff <= s5_pass_ff;
         s6_d_ff    <= s5_d_ff;
         s6_da_ff   <= s5_da_ff;
      end
   end

   // final quotient bits, 8-bit wrap and passthrough select
   aob_pkg::chan_quo_type  s7_quo;
   always_comb begin
      for (int ch = 0; ch < aob_pkg::ChanN; ch++) begin
         s7_quo[ch] = s6_quo_ff[ch] | aob_pkg::quo_type'(d7_quo[ch]);
      end
   end

   // d7_rem is the final remainder: only the quotient is wanted
   aob_pkg::chan_num_type  s7_rem_unused;
   assign s7_rem_unused = d7_rem;

   aob_pkg::chan_pix_type  s7_c_ff;
   aob_pkg::pix_type       s7_alpha_ff;

   always_ff @(posedge clock) begin
      if (stg_rdy[7]) begin
         for (int ch = 0; ch < aob_pkg::ChanN; ch++) begin
            s7_c_ff[ch] <= s6_pass_ff ? s6_d_ff[ch] : s7_quo[ch][aob_pkg::PixW-1:0];
         end
         s7_alpha_ff <= s6_pass_ff ? s6_da_ff : s6_oa_ff;
      end
   end

   assign rsp_px.valid     = vld_ff[Depth];
   assign rsp_px.out_c0    = s7_c_ff[0];
   assign rsp_px.out_c1    = s7_c_ff[1];
   assign rsp_px.out_c2    = s7_c_ff[2];
   assign rsp_px.out_alpha = s7_alpha_ff;

endmodule

FILE: hdl/aob_checker.sv
// Port-level checker for alpha_over_blend and its bind.
`include "alpha_over_blend_assert.svh"

module aob_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input aob_pkg::pix_type rsp_out_c0,
   input aob_pkg::pix_type rsp_out_c1,
   input aob_pkg::pix_type rsp_out_c2,
   input aob_pkg::pix_type rsp_out_alpha
);

   // stalled response keeps its pixel
   `AOB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_c0) && $stable(rsp_out_c1) && $stable(rsp_out_c2) && $stable(rsp_out_alpha), "aob: stalled response changed")

   // reset empties the pipe
   `AOB_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "aob: response valid after reset")

   // no back-pressure unless the output is actually stalled
   `AOB_ASSERT_IMP(a_ready_free, clock, reset, rsp_ready || !rsp_valid, req_ready, "aob: request stalled with free output")

   // an idle request side never produces a response from an empty pipe
   `AOB_ASSERT_NXT(a_empty_stays, clock, reset, !rsp_valid && !req_valid && $past(!rsp_valid && !req_valid, 1) && $past(!rsp_valid && !req_valid, 2) && $past(!rsp_valid && !req_valid, 3) && $past(!rsp_valid && !req_valid, 4) && $past(!rsp_valid && !req_valid, 5) && $past(!rsp_valid && !req_valid, 6) && !$past(reset, 6), !rsp_valid, "aob: response without request")

endmodule

bind alpha_over_blend aob_checker u_aob_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_px.valid),
   .req_ready     (req_px.ready),
   .rsp_valid     (rsp_px.valid),
   .rsp_ready     (rsp_px.ready),
   .rsp_out_c0    (rsp_px.out_c0),
   .rsp_out_c1    (rsp_px.out_c1),
   .rsp_out_c2    (rsp_px.out_c2),
   .rsp_out_alpha (rsp_px.out_alpha)
);

FILE: bench/tb_top.sv
// Self-checking bench for alpha_over_blend: random pixel traffic with back-pressure and checks.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Blend arithmetic constants, 8-bit full scale and half-step for rounding
   localparam int unsigned FULL  = 255;
   localparam int unsigned HALF  = 127;
   localparam int unsigned RANDOM_N   = 784;
   // Tail with no idling on either side, in transfers
   localparam int unsigned CALM_TAIL  = 120;
   // Cycles past the last result, comfortably over the 7-stage pipe
   localparam int unsigned DRAIN_WAIT = 24;
   // Cycles with no transfer on either side before the run is abandoned
   localparam int unsigned STALL_LIMIT = 2000;
   // Receiver hold-off that forces the pipe to fill and back up its input
   localparam int unsigned HOLD_CYCLES = 96;
   localparam int unsigned HOLD_AT     = 300;

   // One request transfer: source pixel then destination pixel
   typedef struct packed {
      aob_pkg::pix_type src_c0;
      aob_pkg::pix_type src_c1;
      aob_pkg::pix_type src_c2;
      aob_pkg::pix_type src_alpha;
      aob_pkg::pix_type dst_c0;
      aob_pkg::pix_type dst_c1;
      aob_pkg::pix_type dst_c2;
      aob_pkg::pix_type dst_alpha;
   } px_pair_type;

   // One response transfer; lane 3 is out_c0, lane 0 is out_alpha
   typedef struct packed {
      aob_pkg::pix_type out_c0;
      aob_pkg::pix_type out_c1;
      aob_pkg::pix_type out_c2;
      aob_pkg::pix_type out_alpha;
   } px_out_type;

   typedef aob_pkg::pix_type [3:0] px_lanes_type;

   logic clock;
   logic reset;

   aob_req_if req_px ();
   aob_rsp_if rsp_px ();

   alpha_over_blend i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_px (req_px),
      .rsp_px (rsp_px)
   );

   px_pair_type pending_q [$];   // pixels still to be offered
   px_out_type  blend_exp_q [$]; // blended pixels owed by the block, oldest first
   string       lane_name [4] = '{"out_alpha", "out_c2", "out_c1", "out_c0"};

   int unsigned px_total;
   int unsigned px_sent;
   int unsigned px_checked;
   int unsigned fault_cnt;
   int unsigned n_clear_src;
   int unsigned n_opaque_src;
   int unsigned n_wrap;
   int unsigned req_gap;
   int unsigned rsp_stall;
   int unsigned rsp_hold;
   bit          hold_done;
   int unsigned quiet_cycles;

   // Append a pixel pair to the tail of the pending queue
   task automatic enqueue_px(input px_pair_type p);
      pending_q = {pending_q, p};
   endtask

   // Source-over blend of straight-alpha pixels.
   // oa = sa + round(da*(255-sa)/255); each channel is the premultiplied sum over oa,
   // rounded half up, with only the low byte kept (a quotient of 256 wraps to 0).
   function automatic px_out_type blend_over(input px_pair_type p, output bit wrapped);
      int unsigned      inv;
      int unsigned      oa;
      int unsigned      num;
      int unsigned      quo;
      aob_pkg::pix_type s [3];
      aob_pkg::pix_type d [3];
      aob_pkg::pix_type c [3];
      px_out_type       r;
      s = '{p.src_c0, p.src_c1, p.src_c2};
      d = '{p.dst_c0, p.dst_c1, p.dst_c2};
      wrapped = 1'b0;
      inv = FULL - p.src_alpha;
      oa  = p.src_alpha + (p.dst_alpha * inv + HALF) / FULL;
      // transparent source, or nothing left to divide by: destination passes through
      if (p.src_alpha == 0 || oa == 0) begin
         r = px_out_type'{p.dst_c0, p.dst_c1, p.dst_c2, p.dst_alpha};
         return r;
      end
      for (int ch = 0; ch < 3; ch++) begin
         num = s[ch] * p.src_alpha + (d[ch] * p.dst_alpha * inv + HALF) / FULL + oa / 2;
         quo = num / oa;
         if (quo > FULL) wrapped = 1'b1;
         c[ch] = quo[7:0];
      end
      r = px_out_type'{c[0], c[1], c[2], oa[7:0]};
      return r;
   endfunction

   // Alpha values lean on the corners where the rounding is most fragile
   function automatic aob_pkg::pix_type pick_alpha();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return aob_pkg::pix_type'($urandom_range(1, 3));
         3: return aob_pkg::pix_type'($urandom_range(252, 254));
         default: return aob_pkg::pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic aob_pkg::pix_type pick_chan();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return aob_pkg::pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Sender: offers pending pixels, holds a pixel while ready is low, idles in bursts.
   // Idling is allowed for two thirds of each 240-transfer stretch and never in the
   // calm tail, so the block also sees long runs of back-to-back transfers.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : px_driver
      px_pair_type cur;
      px_pair_type nxt;
      px_out_type  blended;
      bit          wrapped;
      bit          may_idle;
      if (reset) begin
         req_px.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_px.valid && req_px.ready) begin
            cur = px_pair_type'{req_px.src_c0, req_px.src_c1, req_px.src_c2,
                                req_px.src_alpha, req_px.dst_c0, req_px.dst_c1,
                                req_px.dst_c2, req_px.dst_alpha};
            blended = blend_over(cur, wrapped);
            blend_exp_q = {blend_exp_q, blended};
            px_sent++;
            if (cur.src_alpha == 0)   n_clear_src++;
            if (cur.src_alpha == 255) n_opaque_src++;
            if (wrapped)              n_wrap++;
         end
         may_idle = (px_sent + CALM_TAIL < px_total) && ((px_sent % 240) < 160);
         if (req_px.valid && !req_px.ready) begin
            // offered pixel not yet taken: keep it steady
         end else if (req_gap > 0) begin
            req_gap--;
            req_px.valid <= 1'b0;
         end else if (pending_q.size() > 0 && may_idle && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(1, 17) - 1;
            req_px.valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            nxt = pending_q.pop_front();
            req_px.src_c0    <= nxt.src_c0;
            req_px.src_c1    <= nxt.src_c1;
            req_px.src_c2    <= nxt.src_c2;
            req_px.src_alpha <= nxt.src_alpha;
            req_px.dst_c0    <= nxt.dst_c0;
            req_px.dst_c1    <= nxt.dst_c1;
            req_px.dst_c2    <= nxt.dst_c2;
            req_px.dst_alpha <= nxt.dst_alpha;
            req_px.valid     <= 1'b1;
         end else begin
            req_px.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver: checks every response transfer against the oldest owed pixel, then
   // decides ready for the next cycle. One long hold-off, counted here, lets the pipe
   // fill while the sender keeps offering, so req_px.ready has to drop.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : px_monitor
      px_out_type   got;
      px_out_type   want;
      px_lanes_type got_l;
      px_lanes_type want_l;
      bit           may_stall;
      if (reset) begin
         rsp_px.ready <= 1'b0;
         rsp_stall = 0;
         rsp_hold  = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_px.valid && rsp_px.ready) begin
            got = px_out_type'{rsp_px.out_c0, rsp_px.out_c1, rsp_px.out_c2,
                               rsp_px.out_alpha};
            if (blend_exp_q.size() == 0) begin
               $display("%0t: unexpected result transfer %h, nothing owed", $time, got);
               fault_cnt++;
            end else begin
               want   = blend_exp_q.pop_front();
               got_l  = px_lanes_type'(got);
               want_l = px_lanes_type'(want);
               for (int i = 3; i >= 0; i--) begin
                  if (got_l[i] !== want_l[i]) begin
                     $display("%0t: result %0d %s expected %0d actual %0d", $time,
                              px_checked, lane_name[i], want_l[i], got_l[i]);
                     fault_cnt++;
                  end
               end
            end
            px_checked++;
         end
         may_stall = (px_checked + CALM_TAIL < px_total) && ((px_checked % 200) < 130);
         if (!hold_done && px_checked == HOLD_AT) begin
            hold_done = 1'b1;
            rsp_hold  = HOLD_CYCLES;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_px.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_px.ready <= 1'b0;
         end else if (may_stall && $urandom_range(0, 7) == 0) begin
            rsp_stall = $urandom_range(1, 17) - 1;
            rsp_px.ready <= 1'b0;
         end else begin
            rsp_px.ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long with no transfer on either channel means the block is stuck
   always @(posedge clock) begin : stuck_watch
      if (reset || (req_px.valid && req_px.ready) || (rsp_px.valid && rsp_px.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
         $display("alpha_over_blend regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      px_pair_type p;
      reset            = 1'b1;
      req_px.valid     = 1'b0;
      req_px.src_c0    = '0;
      req_px.src_c1    = '0;
      req_px.src_c2    = '0;
      req_px.src_alpha = '0;
      req_px.dst_c0    = '0;
      req_px.dst_c1    = '0;
      req_px.dst_c2    = '0;
      req_px.dst_alpha = '0;
      rsp_px.ready     = 1'b0;
      px_sent      = 0;
      px_checked   = 0;
      fault_cnt    = 0;
      n_clear_src  = 0;
      n_opaque_src = 0;
      n_wrap       = 0;
      quiet_cycles = 0;

      // Directed corners
      enqueue_px(px_pair_type'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
      enqueue_px(px_pair_type'{8'd255, 8'd255, 8'd255, 8'd255,
                               8'd255, 8'd255, 8'd255, 8'd255});
      // transparent source: destination must come through untouched
      enqueue_px(px_pair_type'{8'd255, 8'd255, 8'd255, 8'd0,
                               8'd12, 8'd34, 8'd56, 8'd78});
      // both transparent
      enqueue_px(px_pair_type'{8'd9, 8'd200, 8'd77, 8'd0,
                               8'd255, 8'd255, 8'd255, 8'd0});
      // opaque source over opaque and over transparent destination, then half alpha over transparent
      enqueue_px(px_pair_type'{8'd0, 8'd128, 8'd255, 8'd255,
                               8'd165, 8'd90, 8'd3, 8'd255});
      enqueue_px(px_pair_type'{8'd17, 8'd34, 8'd51, 8'd255,
                               8'd200, 8'd100, 8'd50, 8'd0});
      enqueue_px(px_pair_type'{8'd40, 8'd240, 8'd1, 8'd128,
                               8'd255, 8'd0, 8'd128, 8'd0});
      // rounding overflow: the quotient can reach 256 and wrap to 0
      enqueue_px(px_pair_type'{8'd255, 8'd255, 8'd255, 8'd1,
                               8'd255, 8'd255, 8'd255, 8'd128});
      enqueue_px(px_pair_type'{8'd255, 8'd255, 8'd255, 8'd2,
                               8'd255, 8'd255, 8'd255, 8'd200});
      enqueue_px(px_pair_type'{8'd255, 8'd255, 8'd255, 8'd1,
                               8'd255, 8'd255, 8'd255, 8'd255});
      enqueue_px(px_pair_type'{8'd255, 8'd0, 8'd128, 8'd1,
                               8'd0, 8'd255, 8'd127, 8'd1});
      enqueue_px(px_pair_type'{8'd100, 8'd150, 8'd200, 8'd128,
                               8'd50, 8'd25, 8'd250, 8'd128});
      enqueue_px(px_pair_type'{8'd1, 8'd254, 8'd128, 8'd254,
                               8'd254, 8'd1, 8'd127, 8'd1});
      // alternating bit patterns on every field, then 7F and 80 mixes
      enqueue_px(px_pair_type'{8'h55, 8'hAA, 8'h55, 8'hAA,
                               8'hAA, 8'h55, 8'hAA, 8'h55});
      enqueue_px(px_pair_type'{8'hAA, 8'h55, 8'hAA, 8'h55,
                               8'h55, 8'hAA, 8'h55, 8'hAA});
      enqueue_px(px_pair_type'{8'h7F, 8'h80, 8'h7F, 8'd127,
                               8'h80, 8'h7F, 8'h80, 8'd127});

      // Random traffic; one pixel in eight is a bright low-alpha pixel that
      // tends to push the rounded quotient over the top
      for (int unsigned n = 0; n < RANDOM_N; n++) begin
         if ($urandom_range(0, 7) == 0) begin
            p = px_pair_type'{8'd255, 8'd255, 8'd255,
                              aob_pkg::pix_type'($urandom_range(1, 8)),
                              8'd255, 8'd255, 8'd255,
                              aob_pkg::pix_type'($urandom_range(64, 255))};
            if ($urandom_range(0, 1)) p.dst_c1 = pick_chan();
         end else begin
            p = px_pair_type'{pick_chan(), pick_chan(), pick_chan(), pick_alpha(),
                              pick_chan(), pick_chan(), pick_chan(), pick_alpha()};
         end
         enqueue_px(p);
      end
      px_total = pending_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Every pixel taken and every blended pixel back
      while (px_sent != px_total || blend_exp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Blended %0d pixels, %0d checked: %0d transparent and %0d opaque sources,",
               px_sent, px_checked, n_clear_src, n_opaque_src);
      $display("%0d pixels with a wrapped channel, one %0d-cycle receiver hold-off.",
               n_wrap, HOLD_CYCLES);
      if (fault_cnt == 0 && blend_exp_q.size() == 0) begin
         $display("alpha_over_blend regression: pass");
      end else begin
         $display("alpha_over_blend regression: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/aob_pkg.sv
hdl/aob_if.sv
hdl/aob_div_step.sv
hdl/alpha_over_blend.sv
hdl/aob_checker.sv
bench/tb_top.sv
